### rtl/sspg_pkg.sv
// sspg_pkg: constants, types and helper functions for the synthetic scene pixel generator
// used by every file under rtl; depends on nothing
`timescale 1ns / 1ps

package sspg_pkg;

    localparam int unsigned FRAME_WIDTH = 640;

    // hash mixer and salts
    localparam logic [31:0] HASH_MUL_A = 32'h7feb352d;
    localparam logic [31:0] HASH_MUL_B = 32'h846ca68b;
    localparam logic [31:0] COL_SALT   = 32'd7919;
    localparam logic [31:0] TREE_SALT  = 32'd2246822519;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HORIZON_ROW    = 3'd0,
        REG_EXPOSURE_SCALE = 3'd1,
        REG_WARMTH         = 3'd2,
        REG_BIRD_X         = 3'd3,
        REG_BIRD_Y         = 3'd4,
        REG_BIRD_RX        = 3'd5,
        REG_BIRD_RY        = 3'd6,
        REG_FRAME_SEED     = 3'd7
    } cfg_reg_t;

    // reset values
    localparam logic [8:0]  RST_HORIZON  = 9'd216;
    localparam logic [23:0] RST_EXPOSURE = 24'd348160;
    localparam logic [15:0] RST_BIRD_X   = 16'd0;
    localparam logic [15:0] RST_BIRD_Y   = 16'd1382;
    localparam logic [23:0] RST_RX2      = 24'd33856;
    localparam logic [23:0] RST_RY2      = 24'd7225;
    localparam logic [47:0] RST_RXRY     = 48'd244609600;
    localparam logic [31:0] RST_SEED     = 32'd0;

    // sky color weights, Q1.10
    localparam logic [10:0] SKY_CR_BASE = 11'd737;
    localparam logic [10:0] SKY_CG_BASE = 11'd860;
    localparam logic [10:0] SKY_CB_BASE = 11'd1024;
    localparam logic [9:0]  SKY_REFL_TOP = 10'd973;
    localparam logic [9:0]  BIRD_REFL    = 10'd51;
    localparam logic [10:0] BIRD_WEIGHT  = 11'd1024;
    localparam logic [10:0] TREE_CR      = 11'd799;
    localparam logic [10:0] TREE_CG      = 11'd942;
    localparam logic [10:0] TREE_CB      = 11'd563;

    // pipelined divider shape
    localparam int DIV_NUM_W = 17;
    localparam int DIV_DEN_W = 9;
    localparam int DIV_QUO_W = 8;
    localparam int DIV_STEPS = 2;

    typedef struct packed {
        logic [8:0]         horizon;
        logic [23:0]        exposure;
        logic signed [15:0] bird_x;
        logic signed [15:0] bird_y;
        logic [31:0]        seed;
        logic [14:0]        w102;
        logic [10:0]        cr_base;
        logic [10:0]        cg;
        logic [10:0]        cb_base;
        logic [23:0]        rx2;
        logic [23:0]        ry2;
        logic [47:0]        rxry;
    } cfg_t;

    // trunc((2k-63)*64/5), division by 5 as reciprocal multiply
    function automatic logic signed [10:0] noise_of(input logic [5:0] k);
        logic signed [7:0] d;
        logic [5:0]        mag;
        logic [27:0]       prod;
        logic [9:0]        q;
        begin
            d    = $signed({1'b0, k, 1'b0}) - 8'sd63;
            mag  = d[7] ? 6'(-d) : 6'(d);
            prod = 28'({mag, 6'b0}) * 28'd52429;
            q    = prod[27:18];
            noise_of = d[7] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        end
    endfunction

    // 195 + floor(184*b/255), division by 255 as reciprocal multiply
    function automatic logic [9:0] tree_refl_of(input logic [7:0] b);
        logic [15:0] p;
        logic [31:0] r;
        begin
            p = 16'(b) * 16'd184;
            r = 32'(p) * 32'd32897;
            tree_refl_of = 10'd195 + 10'(r[30:23]);
        end
    endfunction

endpackage

### rtl/sspg_intf.sv
// sspg channel interfaces: pixel coordinate input, pixel color output, register write
// depends on sspg_pkg
`timescale 1ns / 1ps

interface sspg_pix_in_if;
    logic       valid;
    logic       ready;
    logic [9:0] pixel_x;
    logic [8:0] pixel_y;
    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface sspg_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, output luma, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input luma, input red, input green, input blue,
                    output ready);
endinterface

interface sspg_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sspg_pkg::CFG_IDX_W-1:0]  index;
    logic [sspg_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/sspg_cfg_regs.sv
// sspg_cfg_regs: register file for frame-level settings plus derived color and ellipse terms
// depends on sspg_pkg and sspg_cfg_if
`timescale 1ns / 1ps

module sspg_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    sspg_cfg_if.sink         cfg,
    output sspg_pkg::cfg_t   regs
);

    logic [8:0]         horizon_reg;
    logic [23:0]        exposure_reg;
    logic signed [15:0] bird_x_reg;
    logic signed [15:0] bird_y_reg;
    logic [31:0]        seed_reg;
    logic [14:0]        w102_reg;
    logic [10:0]        cr_base_reg;
    logic [10:0]        cg_reg;
    logic [10:0]        cb_base_reg;
    logic [23:0]        rx2_reg;
    logic [23:0]        ry2_reg;
    logic [47:0]        rxry_reg;

    logic [8:0]  warm_clamp;
    logic [16:0] warm_r;
    logic [16:0] warm_g;
    logic [16:0] warm_b;
    logic [23:0] half_axis_sq;
    logic        wr;

    assign cfg.ready = 1'b1;
    assign wr = cfg.valid && cfg.ready;

    always_comb
    begin
        warm_clamp   = (cfg.data[8:0] > 9'd256) ? 9'd256 : cfg.data[8:0];
        warm_r       = 17'(warm_clamp) * 17'd307;
        warm_g       = 17'(warm_clamp) * 17'd82;
        warm_b       = 17'(warm_clamp) * 17'd369;
        half_axis_sq = 24'(cfg.data[11:0]) * 24'(cfg.data[11:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            horizon_reg  <= sspg_pkg::RST_HORIZON;
            exposure_reg <= sspg_pkg::RST_EXPOSURE;
            bird_x_reg   <= sspg_pkg::RST_BIRD_X;
            bird_y_reg   <= sspg_pkg::RST_BIRD_Y;
            seed_reg     <= sspg_pkg::RST_SEED;
            w102_reg     <= '0;
            cr_base_reg  <= sspg_pkg::SKY_CR_BASE;
            cg_reg       <= sspg_pkg::SKY_CG_BASE;
            cb_base_reg  <= sspg_pkg::SKY_CB_BASE;
            rx2_reg      <= sspg_pkg::RST_RX2;
            ry2_reg      <= sspg_pkg::RST_RY2;
            rxry_reg     <= sspg_pkg::RST_RXRY;
        end
        else
        begin
            // ellipse bound is registered from the squared half-axes and follows them in the next cycle
            rxry_reg <= 48'(rx2_reg) * 48'(ry2_reg);
            if (wr)
            begin
                unique case (sspg_pkg::cfg_reg_t'(cfg.index))
                    sspg_pkg::REG_HORIZON_ROW:    horizon_reg  <= cfg.data[8:0];
                    sspg_pkg::REG_EXPOSURE_SCALE: exposure_reg <= cfg.data[23:0];
                    sspg_pkg::REG_WARMTH:
                    begin
                        w102_reg    <= 15'(warm_clamp) * 15'd102;
                        cr_base_reg <= sspg_pkg::SKY_CR_BASE + 11'(warm_r[16:8]);
                        cg_reg      <= sspg_pkg::SKY_CG_BASE - 11'(warm_g[16:8]);
                        cb_base_reg <= sspg_pkg::SKY_CB_BASE - 11'(warm_b[16:8]);
                    end
                    sspg_pkg::REG_BIRD_X:     bird_x_reg <= cfg.data[15:0];
                    sspg_pkg::REG_BIRD_Y:     bird_y_reg <= cfg.data[15:0];
                    sspg_pkg::REG_BIRD_RX:    rx2_reg    <= half_axis_sq;
                    sspg_pkg::REG_BIRD_RY:    ry2_reg    <= half_axis_sq;
                    sspg_pkg::REG_FRAME_SEED: seed_reg   <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        regs.horizon  = horizon_reg;
        regs.exposure = exposure_reg;
        regs.bird_x   = bird_x_reg;
        regs.bird_y   = bird_y_reg;
        regs.seed     = seed_reg;
        regs.w102     = w102_reg;
        regs.cr_base  = cr_base_reg;
        regs.cg       = cg_reg;
        regs.cb_base  = cb_base_reg;
        regs.rx2      = rx2_reg;
        regs.ry2      = ry2_reg;
        regs.rxry     = rxry_reg;
    end

endmodule

### rtl/sspg_mix32.sv
// sspg_mix32: two-stage pipelined 32-bit integer hash mixer
// depends on sspg_pkg for the multiplier constants
`timescale 1ns / 1ps

module sspg_mix32 (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] din,
    output logic [31:0] dout
);

    logic [31:0] m1_reg;
    logic [31:0] m2_reg;
    logic [31:0] m1_next;
    logic [31:0] m2_next;

    always_comb
    begin
        m1_next = (din ^ (din >> 16)) * sspg_pkg::HASH_MUL_A;
        m2_next = (m1_reg ^ (m1_reg >> 15)) * sspg_pkg::HASH_MUL_B;
        dout    = m2_reg ^ (m2_reg >> 16);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg <= m1_next;
            m2_reg <= m2_next;
        end
    end

endmodule

### rtl/sspg_div.sv
// sspg_div: pipelined restoring divider, a fixed number of quotient bits per stage
// depends on sspg_pkg; the quotient must fit QUO_W bits
`timescale 1ns / 1ps

module sspg_div #(
    parameter int NUM_W = sspg_pkg::DIV_NUM_W,
    parameter int DEN_W = sspg_pkg::DIV_DEN_W,
    parameter int QUO_W = sspg_pkg::DIV_QUO_W
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    localparam int STEPS = sspg_pkg::DIV_STEPS;
    localparam int NSTG  = QUO_W / STEPS;
    localparam int REM_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    for (genvar s = 0; s < NSTG; s++)
    begin : g_stage
        logic [REM_W-1:0] rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [REM_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;
        logic [QUO_W-1:0] quo_s_reg;

        if (s == 0)
        begin : g_first
            assign rem_in = REM_W'(num);
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = g_stage[s-1].g_keep_rem.rem_s_reg;
            assign quo_in = g_stage[s-1].quo_s_reg;
        end

        always_comb
        begin
            rem_next = rem_in;
            quo_next = quo_in;
            for (int j = 0; j < STEPS; j++)
            begin
                if (rem_next >= (REM_W'(den) << (QUO_W - 1 - s * STEPS - j)))
                begin
                    rem_next = rem_next - (REM_W'(den) << (QUO_W - 1 - s * STEPS - j));
                    quo_next[QUO_W - 1 - s * STEPS - j] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_s_reg <= quo_next;
            end
        end

        if (s < NSTG - 1)
        begin : g_keep_rem
            logic [REM_W-1:0] rem_s_reg;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_s_reg <= rem_next;
                end
            end
        end
    end

    assign quo = g_stage[NSTG-1].quo_s_reg;

endmodule

### rtl/synthetic_scene_pixel_generator_unit.sv
// synthetic_scene_pixel_generator_unit: top level of the camera test-pattern generator
// depends on sspg_pkg, sspg_intf, sspg_cfg_regs, sspg_mix32, sspg_div
//
//   channel   dir  payload                       handshake
//   pix_in    in   pixel_x[9:0], pixel_y[8:0]    valid / ready
//   pix_out   out  luma, red, green, blue [7:0]  valid / ready
//   cfg       in   index[2:0], data[31:0]        valid / ready (always ready)
//
// one pixel per clock sustained while pix_out is not stalled; output valid follows the input
// transfer through eight register stages (hash mixers, ellipse products, divider), the first
// loaded by the transfer itself
// rst_n clears valid bits and restores register defaults; pipeline data has no reset
// when pix_out is stalled with a result waiting, the whole pipeline and pix_in hold
`timescale 1ns / 1ps

module synthetic_scene_pixel_generator_unit #(
    parameter int unsigned FRAME_WIDTH = sspg_pkg::FRAME_WIDTH
) (
    input  logic            clk,
    input  logic            rst_n,
    sspg_pix_in_if.sink     pix_in,
    sspg_pix_out_if.source  pix_out,
    sspg_cfg_if.sink        cfg
);

    sspg_pkg::cfg_t regs;

    logic [8:1] vld_reg;
    logic       en;

    // stage 1
    logic [31:0]        hx1_reg;
    logic [31:0]        idx1_reg;
    logic signed [17:0] dx1_reg;
    logic signed [17:0] dy1_reg;
    logic [16:0]        nref1_reg;
    logic [15:0]        tn1_reg;
    logic [8:0]         y1_reg;
    // stage 2
    logic [31:0] tb2_reg;
    logic [31:0] dxx2_reg;
    logic [31:0] dyy2_reg;
    logic [8:0]  y2_reg;
    // stage 3
    logic [55:0] px3_reg;
    logic [55:0] py3_reg;
    logic [8:0]  y3_reg;
    // stage 4
    logic               sky4_reg;
    logic               bird4_reg;
    logic signed [10:0] noise4_reg;
    // stage 5
    logic               sky5_reg;
    logic               bird5_reg;
    logic signed [10:0] noise5_reg;
    logic [9:0]         trefl5_reg;
    // stage 6
    logic [9:0]         refl6_reg;
    logic [10:0]        cr6_reg;
    logic [10:0]        cg6_reg;
    logic [10:0]        cb6_reg;
    logic signed [10:0] noise6_reg;
    // stage 7
    logic signed [25:0] v7_reg;
    logic [10:0]        cr7_reg;
    logic [10:0]        cg7_reg;
    logic [10:0]        cb7_reg;
    // stage 8, output register
    logic [7:0] luma8_reg;
    logic [7:0] red8_reg;
    logic [7:0] green8_reg;
    logic [7:0] blue8_reg;

    // combinational per stage
    logic [31:0]        hx0;
    logic [31:0]        idx0;
    logic signed [17:0] dx0;
    logic signed [17:0] dy0;
    logic [16:0]        nref0;
    logic [23:0]        tn_prod0;
    logic [31:0]        tb1;
    logic signed [35:0] dxx1;
    logic signed [35:0] dyy1;
    logic [31:0]        hash_col;
    logic [31:0]        hash_noise;
    logic [31:0]        hash_tree;
    logic signed [10:0] canopy_row3;
    logic               sky3;
    logic               bird3;
    logic [56:0]        ell_sum3;
    logic [7:0]         q_refl;
    logic [7:0]         q_tint;
    logic [9:0]         refl5;
    logic [10:0]        cr5;
    logic [10:0]        cg5;
    logic [10:0]        cb5;
    logic [33:0]        lum_prod6;
    logic signed [25:0] v6;
    logic [24:0]        vpos7;
    logic [35:0]        pr7;
    logic [35:0]        pg7;
    logic [35:0]        pb7;
    logic [7:0]         luma7;
    logic [7:0]         red7;
    logic [7:0]         green7;
    logic [7:0]         blue7;

    sspg_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    assign en           = !vld_reg[8] || pix_out.ready;
    assign pix_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[7:1], pix_in.valid};
        end
    end

    // stage 0: index, column salt, bird offsets, divider numerators
    always_comb
    begin
        idx0     = 32'(pix_in.pixel_y) * 32'(FRAME_WIDTH) + 32'(pix_in.pixel_x);
        hx0      = 32'(pix_in.pixel_x) * sspg_pkg::COL_SALT;
        dx0      = $signed({4'b0, pix_in.pixel_x, 4'b0}) - 18'(regs.bird_x);
        dy0      = $signed({5'b0, pix_in.pixel_y, 4'b0}) - 18'(regs.bird_y);
        nref0    = 17'(9'(regs.horizon - pix_in.pixel_y)) * 17'd154;
        tn_prod0 = 24'(regs.w102) * 24'(pix_in.pixel_y);
    end

    // stage 1 -> 2: tree hash salt, squared offsets
    always_comb
    begin
        tb1  = idx1_reg * sspg_pkg::TREE_SALT;
        dxx1 = dx1_reg * dx1_reg;
        dyy1 = dy1_reg * dy1_reg;
    end

    sspg_mix32 u_hash_col (
        .clk  (clk),
        .en   (en),
        .din  (hx1_reg),
        .dout (hash_col)
    );

    sspg_mix32 u_hash_noise (
        .clk  (clk),
        .en   (en),
        .din  (idx1_reg ^ regs.seed),
        .dout (hash_noise)
    );

    sspg_mix32 u_hash_tree (
        .clk  (clk),
        .en   (en),
        .din  (tb2_reg),
        .dout (hash_tree)
    );

    sspg_div #(
        .NUM_W (sspg_pkg::DIV_NUM_W),
        .DEN_W (sspg_pkg::DIV_DEN_W),
        .QUO_W (sspg_pkg::DIV_QUO_W)
    ) u_div_refl (
        .clk (clk),
        .en  (en),
        .num (nref1_reg),
        .den (regs.horizon),
        .quo (q_refl)
    );

    sspg_div #(
        .NUM_W (sspg_pkg::DIV_NUM_W),
        .DEN_W (sspg_pkg::DIV_DEN_W),
        .QUO_W (sspg_pkg::DIV_QUO_W)
    ) u_div_tint (
        .clk (clk),
        .en  (en),
        .num (17'(tn1_reg)),
        .den (regs.horizon),
        .quo (q_tint)
    );

    // stage 3: sky vs treeline, ellipse test
    always_comb
    begin
        canopy_row3 = $signed({2'b0, regs.horizon}) - 11'sd16
                      + $signed({6'b0, hash_col[4:0]});
        sky3        = (y3_reg < regs.horizon) && ($signed({2'b0, y3_reg}) < canopy_row3);
        ell_sum3    = 57'(px3_reg) + 57'(py3_reg);
        bird3       = ell_sum3 < 57'(regs.rxry);
    end

    // stage 5: reflectance and channel weights
    always_comb
    begin
        if (sky5_reg)
        begin
            if (bird5_reg)
            begin
                refl5 = sspg_pkg::BIRD_REFL;
                cr5   = sspg_pkg::BIRD_WEIGHT;
                cg5   = sspg_pkg::BIRD_WEIGHT;
                cb5   = sspg_pkg::BIRD_WEIGHT;
            end
            else
            begin
                refl5 = sspg_pkg::SKY_REFL_TOP - 10'(q_refl);
                cr5   = regs.cr_base + 11'(q_tint);
                cg5   = regs.cg;
                cb5   = regs.cb_base - 11'(q_tint);
            end
        end
        else
        begin
            refl5 = trefl5_reg;
            cr5   = sspg_pkg::TREE_CR;
            cg5   = sspg_pkg::TREE_CG;
            cb5   = sspg_pkg::TREE_CB;
        end
    end

    // stage 6: exposure and noise
    always_comb
    begin
        lum_prod6 = 34'(refl6_reg) * 34'(regs.exposure);
        v6        = $signed({2'b0, lum_prod6[33:10]}) + 26'(noise6_reg);
    end

    // stage 7: channel weighting and saturation
    always_comb
    begin
        vpos7 = v7_reg[24:0];
        pr7   = 36'(vpos7) * 36'(cr7_reg);
        pg7   = 36'(vpos7) * 36'(cg7_reg);
        pb7   = 36'(vpos7) * 36'(cb7_reg);
        if (v7_reg <= 26'sd0)
        begin
            luma7  = '0;
            red7   = '0;
            green7 = '0;
            blue7  = '0;
        end
        else
        begin
            luma7  = (vpos7[24:8] > 17'd255) ? 8'd255 : vpos7[15:8];
            red7   = (pr7[35:18] > 18'd255) ? 8'd255 : pr7[25:18];
            green7 = (pg7[35:18] > 18'd255) ? 8'd255 : pg7[25:18];
            blue7  = (pb7[35:18] > 18'd255) ? 8'd255 : pb7[25:18];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hx1_reg    <= hx0;
            idx1_reg   <= idx0;
            dx1_reg    <= dx0;
            dy1_reg    <= dy0;
            nref1_reg  <= nref0;
            tn1_reg    <= tn_prod0[23:8];
            y1_reg     <= pix_in.pixel_y;

            tb2_reg    <= tb1;
            dxx2_reg   <= dxx1[31:0];
            dyy2_reg   <= dyy1[31:0];
            y2_reg     <= y1_reg;

            px3_reg    <= 56'(dxx2_reg) * 56'(regs.ry2);
            py3_reg    <= 56'(dyy2_reg) * 56'(regs.rx2);
            y3_reg     <= y2_reg;

            sky4_reg   <= sky3;
            bird4_reg  <= bird3;
            noise4_reg <= sspg_pkg::noise_of(hash_noise[5:0]);

            sky5_reg   <= sky4_reg;
            bird5_reg  <= bird4_reg;
            noise5_reg <= noise4_reg;
            trefl5_reg <= sspg_pkg::tree_refl_of(hash_tree[7:0]);

            refl6_reg  <= refl5;
            cr6_reg    <= cr5;
            cg6_reg    <= cg5;
            cb6_reg    <= cb5;
            noise6_reg <= noise5_reg;

            v7_reg     <= v6;
            cr7_reg    <= cr6_reg;
            cg7_reg    <= cg6_reg;
            cb7_reg    <= cb6_reg;

            luma8_reg  <= luma7;
            red8_reg   <= red7;
            green8_reg <= green7;
            blue8_reg  <= blue7;
        end
    end

    assign pix_out.valid = vld_reg[8];
    assign pix_out.luma  = luma8_reg;
    assign pix_out.red   = red8_reg;
    assign pix_out.green = green8_reg;
    assign pix_out.blue  = blue8_reg;

endmodule
